FILE: src/lsbc_pkg.sv
// lsbc_pkg: shared constants, register map and types for the line sensor
// binarize and classify block; no dependencies
`timescale 1ns / 1ps

package lsbc_pkg;

  localparam int NumCh             = 7;
  localparam int SampleBitsDefault = 12;
  localparam int CfgBits           = 12;
  localparam int AddrBits          = 5;
  localparam int DataBits          = 32;
  localparam int MaskBits          = 8;

  localparam logic [CfgBits-1:0] WhiteCutoffRst  = 12'd1000;
  localparam logic [CfgBits-1:0] FallbackThrRst  = 12'd2000;
  localparam logic [CfgBits-1:0] ThrMarginRst    = 12'd300;
  localparam logic [CfgBits-1:0] WhiteLevelRst   = 12'd1300;
  localparam logic [CfgBits-1:0] BlackLevelRst   = 12'd3000;

  typedef enum logic [2:0] {
    REG_WHITE_CUTOFF  = 3'd0,
    REG_FALLBACK_THR  = 3'd1,
    REG_THR_MARGIN    = 3'd2,
    REG_WHITE_LEVEL   = 3'd3,
    REG_BLACK_LEVEL   = 3'd4
  } lsbc_reg_e;

  typedef enum logic [1:0] {
    LT_ALL_WHITE  = 2'd0,
    LT_ALL_BLACK  = 2'd1,
    LT_LEFT_JUNC  = 2'd2,
    LT_RIGHT_JUNC = 2'd3
  } lsbc_line_type_e;

  typedef struct packed {
    logic [CfgBits-1:0] white_cutoff;
    logic [CfgBits-1:0] fallback_threshold;
    logic [CfgBits-1:0] threshold_margin;
    logic [CfgBits-1:0] white_level;
    logic [CfgBits-1:0] black_level;
  } lsbc_cfg_t;

endpackage

FILE: src/lsbc_cfg.sv
// lsbc_cfg: apb-style configuration registers with read back
// depends on lsbc_pkg
`timescale 1ns / 1ps

module lsbc_cfg import lsbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready,
  output lsbc_cfg_t           cfg_o
);

  lsbc_cfg_t  cfg_q, cfg_d;
  lsbc_reg_e  reg_sel;
  logic       wr_en;
  logic [CfgBits-1:0] wr_val;
  logic [CfgBits-1:0] rd_val;

  assign reg_sel = lsbc_reg_e'(paddr[AddrBits-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign wr_val  = pwdata[CfgBits-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_WHITE_CUTOFF: cfg_d.white_cutoff       = wr_val;
        REG_FALLBACK_THR: cfg_d.fallback_threshold = wr_val;
        REG_THR_MARGIN:   cfg_d.threshold_margin   = wr_val;
        REG_WHITE_LEVEL:  cfg_d.white_level        = wr_val;
        REG_BLACK_LEVEL:  cfg_d.black_level        = wr_val;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WHITE_CUTOFF: rd_val = cfg_q.white_cutoff;
      REG_FALLBACK_THR: rd_val = cfg_q.fallback_threshold;
      REG_THR_MARGIN:   rd_val = cfg_q.threshold_margin;
      REG_WHITE_LEVEL:  rd_val = cfg_q.white_level;
      REG_BLACK_LEVEL:  rd_val = cfg_q.black_level;
      default:          rd_val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.white_cutoff       <= WhiteCutoffRst;
      cfg_q.fallback_threshold <= FallbackThrRst;
      cfg_q.threshold_margin   <= ThrMarginRst;
      cfg_q.white_level        <= WhiteLevelRst;
      cfg_q.black_level        <= BlackLevelRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign prdata = {{(DataBits-CfgBits){1'b0}}, rd_val};
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

endmodule

FILE: src/lsbc_eval.sv
// lsbc_eval: second maximum, threshold, mask and line type update for one scan
// depends on lsbc_pkg
`timescale 1ns / 1ps

module lsbc_eval import lsbc_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDefault
) (
  input  logic [SAMPLE_BITS-1:0] sample_i [NumCh],
  input  lsbc_cfg_t              cfg_i,
  input  lsbc_line_type_e        held_i,
  output logic [MaskBits-1:0]    mask_o,
  output lsbc_line_type_e        type_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int CW = (SAMPLE_BITS > CfgBits) ? SAMPLE_BITS : CfgBits;

  // top two of a group packed as {top, second}
  function automatic logic [2*SB-1:0] merge2(input logic [2*SB-1:0] a,
                                             input logic [2*SB-1:0] b);
    logic [SB-1:0] a1, a2, b1, b2, top, sec;
    a1 = a[2*SB-1:SB];
    a2 = a[SB-1:0];
    b1 = b[2*SB-1:SB];
    b2 = b[SB-1:0];
    if (a1 >= b1) begin
      top = a1;
      sec = (a2 > b1) ? a2 : b1;
    end else begin
      top = b1;
      sec = (a1 > b2) ? a1 : b2;
    end
    return {top, sec};
  endfunction

  logic [2*SB-1:0] p0, p1, p2, p3, m0, m1, m2;
  logic [SB-1:0]   sec_max;
  logic [CW-1:0]   sec_w, thr;
  logic [SB+1:0]   left_sum, right_sum;
  logic [SB+2:0]   total_sum;
  logic [CW-1:0]   left_q4, right_q4, avg, black_w, white_w;

  assign p0 = {sample_i[0], {SB{1'b0}}};
  assign p1 = {sample_i[1], {SB{1'b0}}};
  assign p2 = {sample_i[2], {SB{1'b0}}};
  assign p3 = {sample_i[3], {SB{1'b0}}};

  always_comb begin
    m0 = merge2(merge2(p0, p1), merge2(p2, p3));
    m1 = merge2(merge2({sample_i[4], {SB{1'b0}}}, {sample_i[5], {SB{1'b0}}}),
                {sample_i[6], {SB{1'b0}}});
    m2 = merge2(m0, m1);
  end

  assign sec_max = m2[SB-1:0];
  assign sec_w   = CW'(sec_max);

  always_comb begin
    if (sec_w < CW'(cfg_i.white_cutoff)) begin
      thr = CW'(cfg_i.fallback_threshold);
    end else if (sec_w > CW'(cfg_i.threshold_margin)) begin
      thr = sec_w - CW'(cfg_i.threshold_margin);
    end else begin
      thr = '0;
    end
  end

  always_comb begin
    mask_o[0] = CW'(sample_i[0]) <= thr;
    mask_o[1] = CW'(sample_i[1]) <= thr;
    mask_o[2] = CW'(sample_i[2]) <= thr;
    mask_o[3] = CW'(sample_i[3]) <= thr;
    mask_o[4] = CW'(sample_i[3]) <= thr;
    mask_o[5] = CW'(sample_i[4]) <= thr;
    mask_o[6] = CW'(sample_i[5]) <= thr;
    mask_o[7] = CW'(sample_i[6]) <= thr;
  end

  // center channel counts in both halves
  assign left_sum  = (SB+2)'(sample_i[0]) + (SB+2)'(sample_i[1])
                   + (SB+2)'(sample_i[2]) + (SB+2)'(sample_i[3]);
  assign right_sum = (SB+2)'(sample_i[3]) + (SB+2)'(sample_i[4])
                   + (SB+2)'(sample_i[5]) + (SB+2)'(sample_i[6]);
  assign total_sum = (SB+3)'(left_sum) + (SB+3)'(right_sum);

  assign left_q4  = CW'(left_sum[SB+1:2]);
  assign right_q4 = CW'(right_sum[SB+1:2]);
  assign avg      = CW'(total_sum[SB+2:3]);
  assign black_w  = CW'(cfg_i.black_level);
  assign white_w  = CW'(cfg_i.white_level);

  always_comb begin
    type_o = held_i;
    if (left_q4 > black_w) begin
      type_o = LT_LEFT_JUNC;
    end
    if (right_q4 > black_w) begin
      type_o = LT_RIGHT_JUNC;
    end
    if (avg < white_w) begin
      type_o = LT_ALL_WHITE;
    end else if (avg > black_w) begin
      type_o = LT_ALL_BLACK;
    end
  end

endmodule

FILE: src/line_sensor_binarize_classify.sv
// line_sensor_binarize_classify: top level with scan register, result register
// and held line type; depends on lsbc_pkg, lsbc_cfg, lsbc_eval
// path: a transferred scan enters the scan register and moves into the result register
// once that register is free; throughput: one scan per cycle while out_stall_i is low,
// set by the combinational evaluation between the scan register and the result register
// reset: configuration returns to its defaults, held line type to all white,
// both pipeline registers empty
`timescale 1ns / 1ps

module line_sensor_binarize_classify import lsbc_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [AddrBits-1:0]    paddr,
  input  logic [DataBits-1:0]    pwdata,
  output logic [DataBits-1:0]    prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sensor_0_i,
  input  logic [SAMPLE_BITS-1:0] sensor_1_i,
  input  logic [SAMPLE_BITS-1:0] sensor_2_i,
  input  logic [SAMPLE_BITS-1:0] sensor_3_i,
  input  logic [SAMPLE_BITS-1:0] sensor_4_i,
  input  logic [SAMPLE_BITS-1:0] sensor_5_i,
  input  logic [SAMPLE_BITS-1:0] sensor_6_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [MaskBits-1:0]    line_mask_o,
  output logic [1:0]             line_type_o
);

  lsbc_cfg_t cfg;

  logic                   in_valid_q, in_valid_d;
  logic [SAMPLE_BITS-1:0] sample_q [NumCh];
  logic                   out_valid_q, out_valid_d;
  logic [MaskBits-1:0]    mask_q;
  lsbc_line_type_e        type_q;
  lsbc_line_type_e        held_q, held_d;
  logic [MaskBits-1:0]    mask_calc;
  lsbc_line_type_e        type_calc;
  logic                   out_free, advance, in_load;

  lsbc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lsbc_eval #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_eval (
    .sample_i (sample_q),
    .cfg_i    (cfg),
    .held_i   (held_q),
    .mask_o   (mask_calc),
    .type_o   (type_calc)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign in_load     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_load || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);
  assign held_d      = advance ? type_calc : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      held_q      <= LT_ALL_WHITE;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      held_q      <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      sample_q[0] <= sensor_0_i;
      sample_q[1] <= sensor_1_i;
      sample_q[2] <= sensor_2_i;
      sample_q[3] <= sensor_3_i;
      sample_q[4] <= sensor_4_i;
      sample_q[5] <= sensor_5_i;
      sample_q[6] <= sensor_6_i;
    end
    if (advance) begin
      mask_q <= mask_calc;
      type_q <= type_calc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign line_mask_o = mask_q;
  assign line_type_o = type_q;

`ifndef SYNTHESIS
  a_held_only_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(held_q))
    else $error("held line type changed without a transfer");

  a_result_matches_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (type_q == held_q))
    else $error("presented line type differs from held type");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("evaluated scan lost before result register");

  a_empty_stage_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("stall raised with empty scan register");
`endif

endmodule

FILE: tb/tb_line_sensor_binarize_classify.sv
// tb_line_sensor_binarize_classify: self-checking bench for the line sensor binarize and
// classify block; predicts mask and line type per scan and compares every result transfer
// depends on lsbc_pkg and line_sensor_binarize_classify
`timescale 1ns / 1ps

module tb_line_sensor_binarize_classify;
  import lsbc_pkg::*;

  localparam int SampleBits = SampleBitsDefault;
  localparam int MaxSample  = (1 << SampleBits) - 1;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 4;

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [NumCh-1:0][SampleBits-1:0] scan_t;

  typedef struct packed {
    logic [MaskBits-1:0] mask;
    lsbc_line_type_e     line_type;
  } scan_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrBits-1:0] paddr;
  logic [DataBits-1:0] pwdata;
  logic [DataBits-1:0] prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  sample_t             sensor_0_i, sensor_1_i, sensor_2_i, sensor_3_i;
  sample_t             sensor_4_i, sensor_5_i, sensor_6_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [MaskBits-1:0] line_mask_o;
  logic [1:0]          line_type_o;

  scan_t           scan_at_port;
  lsbc_cfg_t       cfg_model;
  lsbc_line_type_e held_type;
  scan_result_t    pending_results[$];
  int              error_count;
  int              cycle_count;
  int              sender_idle_pct;
  int              stall_pct;
  int              holdoff_cycles;

  line_sensor_binarize_classify #(
    .SAMPLE_BITS(SampleBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sensor_0_i (sensor_0_i),
    .sensor_1_i (sensor_1_i),
    .sensor_2_i (sensor_2_i),
    .sensor_3_i (sensor_3_i),
    .sensor_4_i (sensor_4_i),
    .sensor_5_i (sensor_5_i),
    .sensor_6_i (sensor_6_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .line_mask_o(line_mask_o),
    .line_type_o(line_type_o)
  );

  assign scan_at_port = {sensor_6_i, sensor_5_i, sensor_4_i, sensor_3_i,
                         sensor_2_i, sensor_1_i, sensor_0_i};

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  // mask bits per channel, center channel drives two
  function automatic logic [MaskBits-1:0] channel_bits(input int ch);
    if (ch < 3) begin
      return MaskBits'(1 << ch);
    end else if (ch == 3) begin
      return 8'h18;
    end
    return MaskBits'(1 << (ch + 1));
  endfunction

  // threshold from second max, mask, then line type update of the held copy
  function automatic scan_result_t classify_scan(input scan_t sc);
    int           top_ch;
    int           second_max;
    int           thr;
    int           left_sum;
    int           right_sum;
    int           avg;
    scan_result_t res;
    top_ch = 0;
    for (int i = 1; i < NumCh; i++) begin
      if (sc[i] > sc[top_ch]) begin
        top_ch = i;
      end
    end
    second_max = 0;
    for (int i = 0; i < NumCh; i++) begin
      if (i != top_ch && int'(sc[i]) > second_max) begin
        second_max = int'(sc[i]);
      end
    end
    if (second_max < int'(cfg_model.white_cutoff)) begin
      thr = int'(cfg_model.fallback_threshold);
    end else if (second_max > int'(cfg_model.threshold_margin)) begin
      thr = second_max - int'(cfg_model.threshold_margin);
    end else begin
      thr = 0;
    end
    res.mask = '0;
    for (int i = 0; i < NumCh; i++) begin
      if (int'(sc[i]) <= thr) begin
        res.mask |= channel_bits(i);
      end
    end
    left_sum  = int'(sc[0]) + int'(sc[1]) + int'(sc[2]) + int'(sc[3]);
    right_sum = int'(sc[3]) + int'(sc[4]) + int'(sc[5]) + int'(sc[6]);
    avg       = (left_sum + right_sum) >> 3;
    if ((left_sum >> 2) > int'(cfg_model.black_level)) begin
      held_type = LT_LEFT_JUNC;
    end
    if ((right_sum >> 2) > int'(cfg_model.black_level)) begin
      held_type = LT_RIGHT_JUNC;
    end
    if (avg < int'(cfg_model.white_level)) begin
      held_type = LT_ALL_WHITE;
    end else if (avg > int'(cfg_model.black_level)) begin
      held_type = LT_ALL_BLACK;
    end
    res.line_type = held_type;
    return res;
  endfunction

  function automatic scan_t uniform_scan(input int level);
    scan_t sc;
    for (int i = 0; i < NumCh; i++) begin
      sc[i] = sample_t'(level);
    end
    return sc;
  endfunction

  function automatic scan_t scan_of(input int a0, a1, a2, a3, a4, a5, a6);
    return {sample_t'(a6), sample_t'(a5), sample_t'(a4), sample_t'(a3),
            sample_t'(a2), sample_t'(a1), sample_t'(a0)};
  endfunction

  // mostly shaped scans: white floor, black field, junctions, a line, mid band, extremes
  function automatic scan_t random_scan();
    scan_t sc;
    int    mode;
    int    pos;
    mode = $urandom_range(8);
    pos  = $urandom_range(NumCh - 1);
    for (int i = 0; i < NumCh; i++) begin
      case (mode)
        0, 1: begin
          sc[i] = sample_t'($urandom);
        end
        2: begin
          sc[i] = sample_t'($urandom_range(1200));
        end
        3: begin
          sc[i] = sample_t'($urandom_range(MaxSample, 2800));
        end
        4: begin
          sc[i] = (i <= 3) ? sample_t'($urandom_range(MaxSample, 2900))
                           : sample_t'($urandom_range(2000));
        end
        5: begin
          sc[i] = (i >= 3) ? sample_t'($urandom_range(MaxSample, 2900))
                           : sample_t'($urandom_range(2000));
        end
        6: begin
          sc[i] = (i == pos || i == pos + 1) ? sample_t'($urandom_range(MaxSample, 2500))
                                             : sample_t'($urandom_range(1500));
        end
        7: begin
          sc[i] = sample_t'($urandom_range(3100, 1200));
        end
        default: begin
          case ($urandom_range(3))
            0: sc[i] = '0;
            1: sc[i] = sample_t'(MaxSample);
            2: sc[i] = sample_t'($urandom_range(8));
            default: sc[i] = sample_t'($urandom_range(MaxSample, MaxSample - 8));
          endcase
        end
      endcase
    end
    return sc;
  endfunction

  // prediction on every input transfer
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_results.push_back(classify_scan(scan_at_port));
    end
  end

  always @(posedge clk_i) begin : check_result
    scan_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result: mask %h type %0d",
               line_mask_o, line_type_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (line_mask_o !== want.mask) begin
          $error("line_mask expected %h actual %h", want.mask, line_mask_o);
          error_count++;
        end
        if (line_type_o !== want.line_type) begin
          $error("line_type expected %0d actual %0d", want.line_type, line_type_o);
          error_count++;
        end
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk_i) begin
    if (holdoff_cycles > 0) begin
      out_stall_i    <= 1'b1;
      holdoff_cycles <= holdoff_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic apb_write(input lsbc_reg_e idx, input logic [DataBits-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrBits'(int'(idx) * 4);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input lsbc_reg_e idx, output logic [DataBits-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrBits'(int'(idx) * 4);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_register(input lsbc_reg_e idx, input logic [CfgBits-1:0] want);
    logic [DataBits-1:0] got;
    apb_read(idx, got);
    if (got[CfgBits-1:0] !== want) begin
      $error("register %s expected %0d actual %0d", idx.name(), want, got[CfgBits-1:0]);
      error_count++;
    end
  endtask

  // upper data bits are junk on purpose, the register keeps only its low bits
  task automatic set_register(input lsbc_reg_e idx, input int value);
    logic [CfgBits-1:0]  v;
    logic [DataBits-1:0] word;
    v    = CfgBits'(value);
    word = DataBits'($urandom);
    word[CfgBits-1:0] = v;
    apb_write(idx, word);
    case (idx)
      REG_WHITE_CUTOFF: cfg_model.white_cutoff       = v;
      REG_FALLBACK_THR: cfg_model.fallback_threshold = v;
      REG_THR_MARGIN:   cfg_model.threshold_margin   = v;
      REG_WHITE_LEVEL:  cfg_model.white_level        = v;
      default:          cfg_model.black_level        = v;
    endcase
    check_register(idx, v);
  endtask

  task automatic set_config(input int cutoff, fallback, margin, white, black);
    set_register(REG_WHITE_CUTOFF, cutoff);
    set_register(REG_FALLBACK_THR, fallback);
    set_register(REG_THR_MARGIN, margin);
    set_register(REG_WHITE_LEVEL, white);
    set_register(REG_BLACK_LEVEL, black);
  endtask

  task automatic set_default_config();
    set_config(WhiteCutoffRst, FallbackThrRst, ThrMarginRst, WhiteLevelRst, BlackLevelRst);
  endtask

  // valid stays high from one transfer into the next unless a gap is drawn
  task automatic send_scan(input scan_t sc);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sensor_0_i <= sc[0];
    sensor_1_i <= sc[1];
    sensor_2_i <= sc[2];
    sensor_3_i <= sc[3];
    sensor_4_i <= sc[4];
    sensor_5_i <= sc[5];
    sensor_6_i <= sc[6];
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_scan(random_scan());
    end
  endtask

  task automatic test_register_defaults();
    check_register(REG_WHITE_CUTOFF, WhiteCutoffRst);
    check_register(REG_FALLBACK_THR, FallbackThrRst);
    check_register(REG_THR_MARGIN, ThrMarginRst);
    check_register(REG_WHITE_LEVEL, WhiteLevelRst);
    check_register(REG_BLACK_LEVEL, BlackLevelRst);
  endtask

  task automatic test_directed_scans();
    sender_idle_pct = 0;
    stall_pct       = 0;
    send_scan(uniform_scan(0));
    send_scan(uniform_scan(MaxSample));
    send_scan(scan_of(0, 0, 0, MaxSample, 0, 0, 0));
    send_scan(scan_of(MaxSample, 0, 0, 0, 0, 0, MaxSample));
    // second max just below and at the white cutoff
    send_scan(scan_of(999, 999, 0, 0, 0, 0, 0));
    send_scan(scan_of(1000, 0, 0, 0, 0, 0, 1000));
    // samples at and just above the threshold
    send_scan(scan_of(1000, 700, 701, 699, 1000, 0, 700));
    send_scan(scan_of(3200, 3200, 3200, 3200, 0, 0, 0));
    send_scan(uniform_scan(2000));
    send_scan(scan_of(0, 0, 0, 3200, 3200, 3200, 3200));
    send_scan(uniform_scan(2000));
    send_scan(uniform_scan(1300));
    send_scan(uniform_scan(1299));
    send_scan(uniform_scan(1300));
    send_scan(uniform_scan(3000));
    send_scan(uniform_scan(3001));
    send_scan(scan_of(MaxSample, MaxSample, 0, 0, 0, 0, 0));
    for (int ch = 0; ch < NumCh; ch++) begin
      send_scan(scan_of(ch == 0 ? MaxSample : 1500, ch == 1 ? MaxSample : 1500,
                        ch == 2 ? MaxSample : 1500, ch == 3 ? MaxSample : 1500,
                        ch == 4 ? MaxSample : 1500, ch == 5 ? MaxSample : 1500,
                        ch == 6 ? MaxSample : 1500));
    end
    wait_drained();
  endtask

  // second max at or under the margin clamps the threshold to zero, just above it does not
  task automatic test_threshold_clamp();
    set_config(0, 2000, 500, 1300, 3000);
    send_scan(scan_of(500, 500, 0, 0, 0, 0, 0));
    send_scan(scan_of(300, 0, 300, 0, 0, 0, 0));
    send_scan(uniform_scan(0));
    send_scan(scan_of(501, 501, 1, 0, 1, 2, 0));
    wait_drained();
  endtask

  task automatic test_config_extremes();
    sender_idle_pct = 15;
    stall_pct       = 15;
    for (int k = 0; k < 7; k++) begin
      case (k)
        0: set_config(0, 0, 0, 0, 0);
        1: set_config(MaxSample, MaxSample, MaxSample, MaxSample, MaxSample);
        2: set_config(MaxSample, 0, MaxSample, 0, MaxSample);
        3: set_config(0, MaxSample, MaxSample, MaxSample, 0);
        default: set_config($urandom_range(MaxSample), $urandom_range(MaxSample),
                            $urandom_range(MaxSample), $urandom_range(MaxSample),
                            $urandom_range(MaxSample));
      endcase
      send_random(30);
      wait_drained();
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      if (phase % 2 == 0) begin
        set_default_config();
      end else begin
        set_config($urandom_range(2000), $urandom_range(MaxSample), $urandom_range(1000),
                   $urandom_range(2000, 500), $urandom_range(3500, 2000));
      end
      case (phase)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 59; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 59; end
        default: begin sender_idle_pct = 15; stall_pct = 15; end
      endcase
      send_random(200);
      wait_drained();
    end
  endtask

  // receiver holds off while the sender keeps offering, drain, then random stalls, drain
  task automatic test_backpressure();
    set_default_config();
    sender_idle_pct = 0;
    stall_pct       = 0;
    holdoff_cycles  = 200;
    send_random(40);
    wait_drained();
    stall_pct = 59;
    send_random(20);
    wait_drained();
  endtask

  initial begin
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_valid_i      <= 1'b0;
    sensor_0_i      <= '0;
    sensor_1_i      <= '0;
    sensor_2_i      <= '0;
    sensor_3_i      <= '0;
    sensor_4_i      <= '0;
    sensor_5_i      <= '0;
    sensor_6_i      <= '0;
    out_stall_i     <= 1'b0;
    error_count     = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    holdoff_cycles  = 0;
    held_type       = LT_ALL_WHITE;
    cfg_model       = '{WhiteCutoffRst, FallbackThrRst, ThrMarginRst, WhiteLevelRst,
                        BlackLevelRst};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_register_defaults();
    test_directed_scans();
    test_threshold_clamp();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();
    wait_drained();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
